>>> design/csjr_pkg.sv
// ----------------------------------------------------------------------------
// csjr_pkg: shared types and constants of the CAN slave job reassembler
// Field widths, event codes, register indexes and the state record.
// ----------------------------------------------------------------------------
package csjr_pkg;

  localparam int unsigned ID_W      = 29;
  localparam int unsigned DLC_W     = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned CHUNK_W   = 56;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned NUM_W     = 8;
  localparam int unsigned TOTAL_W   = 8;
  localparam int unsigned EVENT_W   = 4;
  localparam int unsigned HELLO_W   = 16;
  localparam int unsigned JOBT_W    = 20;
  localparam int unsigned JOBLEN_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 48;

  localparam logic [DLC_W-1:0]   DLC_MAX    = 4'd8;
  localparam logic [DLC_W-1:0]   DLC_ASSIGN = 4'd7;
  localparam logic [7:0]         SEQ_FIRST  = 8'h00;
  localparam logic [7:0]         SEQ_LAST   = 8'hFF;

  localparam logic [HELLO_W-1:0]  HELLO_PERIOD_RST = 16'd1000;
  localparam logic [JOBT_W-1:0]   JOB_TIMEOUT_RST  = 20'd10000;
  localparam logic [JOBLEN_W-1:0] JOB_LENGTH_RST   = 8'd86;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE        = 4'd0,
    EV_HELLO       = 4'd1,
    EV_BOOT_RENEG  = 4'd2,
    EV_ASSIGNED    = 4'd3,
    EV_TIMEOUT     = 4'd4,
    EV_SETTINGS    = 4'd5,
    EV_JOB_START   = 4'd6,
    EV_JOB_MIDDLE  = 4'd7,
    EV_JOB_OK      = 4'd8,
    EV_JOB_BAD_LEN = 4'd9,
    EV_OVERFLOW    = 4'd10
  } csjr_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATION_ADDRESS = 3'd0,
    CFG_BOOT_FRAME_ID   = 3'd1,
    CFG_ASSIGN_FRAME_ID = 3'd2,
    CFG_SETTINGS_BASE   = 3'd3,
    CFG_JOB_BASE        = 3'd4,
    CFG_HELLO_PERIOD    = 3'd5,
    CFG_JOB_TIMEOUT     = 3'd6,
    CFG_JOB_LENGTH      = 3'd7
  } csjr_cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   station_address;
    logic [ID_W-1:0]     boot_frame_id;
    logic [ID_W-1:0]     assign_frame_id;
    logic [ID_W-1:0]     settings_id_base;
    logic [ID_W-1:0]     job_id_base;
    logic [HELLO_W-1:0]  hello_period;
    logic [JOBT_W-1:0]   job_timeout;
    logic [JOBLEN_W-1:0] job_length;
  } csjr_cfg_t;

  typedef struct packed {
    logic                is_assigned;
    logic [NUM_W-1:0]    own_number;
    logic                in_job;
    logic [TOTAL_W-1:0]  gathered_bytes;
    logic [HELLO_W-1:0]  since_hello;
    logic [JOBT_W-1:0]   since_job;
  } csjr_state_t;

  typedef struct packed {
    logic                mode;
    logic [ID_W-1:0]     frame_id;
    logic [DLC_W-1:0]    frame_length;
    logic [DATA_W-1:0]   frame_data;
  } csjr_item_t;

  typedef struct packed {
    csjr_event_t         event_res;
    logic [NUM_W-1:0]    slave_number;
    logic [CHUNK_W-1:0]  chunk_bytes;
    logic [CNT_W-1:0]    chunk_count;
    logic                dropped_partial;
    logic [TOTAL_W-1:0]  job_total;
  } csjr_result_t;

endpackage

>>> design/csjr_if.sv
// ----------------------------------------------------------------------------
// csjr_if: valid/ready channels of the CAN slave job reassembler
// One interface for received items, one for result items.
// ----------------------------------------------------------------------------
interface csjr_in_if;
  import csjr_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [ID_W-1:0]   frame_id;
  logic [DLC_W-1:0]  frame_length;
  logic [DATA_W-1:0] frame_data;

  modport source (output valid, mode, frame_id, frame_length, frame_data, input ready);
  modport sink   (input valid, mode, frame_id, frame_length, frame_data, output ready);
endinterface

interface csjr_out_if;
  import csjr_pkg::*;

  logic                valid;
  logic                ready;
  logic [EVENT_W-1:0]  event_res;
  logic [NUM_W-1:0]    slave_number;
  logic [CHUNK_W-1:0]  chunk_bytes;
  logic [CNT_W-1:0]    chunk_count;
  logic                dropped_partial;
  logic [TOTAL_W-1:0]  job_total;

  modport source (output valid, event_res, slave_number, chunk_bytes, chunk_count,
                  dropped_partial, job_total, input ready);
  modport sink   (input valid, event_res, slave_number, chunk_bytes, chunk_count,
                  dropped_partial, job_total, output ready);
endinterface

>>> design/csjr_step.sv
// ----------------------------------------------------------------------------
// csjr_step: next-state and result logic for one item
// Negotiation, timeout and job deframing decisions for one frame or tick.
// ----------------------------------------------------------------------------
module csjr_step #(
  parameter int unsigned BUFFER_BYTES = 128
) (
  input  csjr_pkg::csjr_item_t   item,
  input  csjr_pkg::csjr_state_t  st,
  input  csjr_pkg::csjr_cfg_t    cfg,
  output csjr_pkg::csjr_state_t  st_nxt,
  output csjr_pkg::csjr_result_t res
);
  import csjr_pkg::*;

  logic [DLC_W-1:0]   len_c;
  logic [CNT_W-1:0]   dlen;
  logic [7:0]         seq;
  logic [ID_W-1:0]    settings_id;
  logic [ID_W-1:0]    job_id;
  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W:0]   sum;
  logic [CNT_W-1:0]   cnt;
  logic [CHUNK_W-1:0] mask;
  csjr_event_t        ev;
  logic               dropped;

  assign len_c       = (item.frame_length > DLC_MAX) ? DLC_MAX : item.frame_length;
  assign dlen        = CNT_W'(len_c - 4'd1);
  assign seq         = item.frame_data[7:0];
  assign settings_id = cfg.settings_id_base | {{(ID_W-NUM_W){1'b0}}, st.own_number};
  assign job_id      = cfg.job_id_base | {{(ID_W-NUM_W){1'b0}}, st.own_number};
  // A first chunk restarts the byte count before the buffer check.
  assign base        = (seq == SEQ_FIRST) ? '0 : st.gathered_bytes;
  assign sum         = {1'b0, base} + {{(TOTAL_W+1-CNT_W){1'b0}}, dlen};

  always_comb begin
    st_nxt  = st;
    ev      = EV_NONE;
    cnt     = '0;
    dropped = 1'b0;
    if (item.mode) begin
      if (st.since_hello != '1) st_nxt.since_hello = st.since_hello + 1'b1;
      if (st.since_job != '1)   st_nxt.since_job   = st.since_job + 1'b1;
      if (!st.is_assigned && st_nxt.since_hello >= cfg.hello_period) begin
        ev                 = EV_HELLO;
        st_nxt.since_hello = '0;
      end
    end else if (item.frame_id == cfg.boot_frame_id) begin
      st_nxt.is_assigned    = 1'b0;
      st_nxt.own_number     = '0;
      st_nxt.in_job         = 1'b0;
      st_nxt.gathered_bytes = '0;
      st_nxt.since_hello    = '1;
      ev                    = EV_BOOT_RENEG;
    end else if (item.frame_id == cfg.assign_frame_id && len_c == DLC_ASSIGN) begin
      if (item.frame_data[ADDR_W-1:0] == cfg.station_address) begin
        st_nxt.own_number  = item.frame_data[ADDR_W+:NUM_W];
        st_nxt.is_assigned = 1'b1;
        st_nxt.since_job   = '0;
        ev                 = EV_ASSIGNED;
      end
    end else if (!st.is_assigned) begin
      ev = EV_NONE;
    end else if (st.since_job >= cfg.job_timeout) begin
      st_nxt.is_assigned    = 1'b0;
      st_nxt.own_number     = '0;
      st_nxt.in_job         = 1'b0;
      st_nxt.gathered_bytes = '0;
      st_nxt.since_hello    = '1;
      ev                    = EV_TIMEOUT;
    end else if (item.frame_id == settings_id) begin
      if (len_c >= 4'd2 && seq == SEQ_LAST) begin
        ev  = EV_SETTINGS;
        cnt = dlen;
      end
    end else if (item.frame_id == job_id && len_c != '0) begin
      if (seq == SEQ_FIRST || st.in_job) begin
        if (sum > (TOTAL_W+1)'(BUFFER_BYTES)) begin
          st_nxt.in_job         = 1'b0;
          st_nxt.gathered_bytes = base;
          ev                    = EV_OVERFLOW;
        end else begin
          st_nxt.gathered_bytes = sum[TOTAL_W-1:0];
          cnt                   = dlen;
          if (seq == SEQ_LAST) begin
            st_nxt.in_job    = 1'b0;
            st_nxt.since_job = '0;
            ev = (sum[TOTAL_W-1:0] == cfg.job_length) ? EV_JOB_OK : EV_JOB_BAD_LEN;
          end else if (seq == SEQ_FIRST) begin
            st_nxt.in_job = 1'b1;
            dropped       = st.in_job;
            ev            = EV_JOB_START;
          end else begin
            ev = EV_JOB_MIDDLE;
          end
        end
      end
    end
  end

  // Keep only the first cnt bytes after the sequence byte.
  always_comb begin
    for (int k = 0; k < CHUNK_W/8; k++) begin
      mask[8*k +: 8] = {8{CNT_W'(k) < cnt}};
    end
  end

  assign res.event_res       = ev;
  assign res.slave_number    = st_nxt.own_number;
  assign res.chunk_bytes     = item.frame_data[DATA_W-1:8] & mask;
  assign res.chunk_count     = cnt;
  assign res.dropped_partial = dropped;
  assign res.job_total       = st_nxt.gathered_bytes;

endmodule

>>> design/can_slave_job_reassembler_core.sv
// ----------------------------------------------------------------------------
// can_slave_job_reassembler_core: CAN slave negotiation and job deframing
// Takes received frames and millisecond ticks, tracks slave assignment and
// job timeout, and streams reassembled job chunks as result transfers.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Carries
//   in_chan   sink       valid/ready    mode, frame_id, frame_length, frame_data
//   out_chan  source     valid/ready    event, slave number, chunk, job total
//   cfg_*     input      write enable   eight registers, index 0 to 7
//
// Every item yields exactly one result transfer, after passing through the
// input register and then the result register. The block sustains one item
// per cycle while the result is not stalled; the combinational state update
// in csjr_step allows that rate. A stalled result holds the result register,
// and the input register takes a new item only when it can move on, so
// nothing is dropped. Reset (rst_n low, synchronous) clears both valid flags
// and returns the slave state and configuration registers to reset values.
//
module can_slave_job_reassembler_core #(
  parameter int unsigned BUFFER_BYTES = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  csjr_in_if.sink                        in_chan,
  csjr_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [csjr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csjr_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import csjr_pkg::*;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  csjr_cfg_t    cfg_r;

  // Input register stage.
  logic         in_v_r;
  csjr_item_t   item_r;

  // Slave state and the result register.
  csjr_state_t  st_r;
  csjr_state_t  st_nxt;
  logic         out_v_r;
  csjr_result_t res_r;
  csjr_result_t res_nxt;

  logic         adv;
  logic         in_take;

  // The item in the input register moves on when the result register is
  // free or is being emptied in this cycle.
  assign adv     = in_v_r && (!out_v_r || out_chan.ready);
  assign in_take = in_chan.valid && in_chan.ready;

  assign in_chan.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station_address  <= '0;
      cfg_r.boot_frame_id    <= '0;
      cfg_r.assign_frame_id  <= '0;
      cfg_r.settings_id_base <= '0;
      cfg_r.job_id_base      <= '0;
      cfg_r.hello_period     <= HELLO_PERIOD_RST;
      cfg_r.job_timeout      <= JOB_TIMEOUT_RST;
      cfg_r.job_length       <= JOB_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (csjr_cfg_idx_t'(cfg_index))
        CFG_STATION_ADDRESS: cfg_r.station_address  <= cfg_wdata[ADDR_W-1:0];
        CFG_BOOT_FRAME_ID:   cfg_r.boot_frame_id    <= cfg_wdata[ID_W-1:0];
        CFG_ASSIGN_FRAME_ID: cfg_r.assign_frame_id  <= cfg_wdata[ID_W-1:0];
        CFG_SETTINGS_BASE:   cfg_r.settings_id_base <= cfg_wdata[ID_W-1:0];
        CFG_JOB_BASE:        cfg_r.job_id_base      <= cfg_wdata[ID_W-1:0];
        CFG_HELLO_PERIOD:    cfg_r.hello_period     <= cfg_wdata[HELLO_W-1:0];
        CFG_JOB_TIMEOUT:     cfg_r.job_timeout      <= cfg_wdata[JOBT_W-1:0];
        CFG_JOB_LENGTH:      cfg_r.job_length       <= cfg_wdata[JOBLEN_W-1:0];
        default:             cfg_r                  <= cfg_r;
      endcase
    end
  end

  // Input register: the valid flag is control state, the item is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode         <= in_chan.mode;
      item_r.frame_id     <= in_chan.frame_id;
      item_r.frame_length <= in_chan.frame_length;
      item_r.frame_data   <= in_chan.frame_data;
    end
  end

  csjr_step #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_step (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Slave state advances exactly once per item, when it enters the result
  // register; since_hello starts saturated so the first tick requests hello.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.is_assigned    <= 1'b0;
      st_r.own_number     <= '0;
      st_r.in_job         <= 1'b0;
      st_r.gathered_bytes <= '0;
      st_r.since_hello    <= '1;
      st_r.since_job      <= '0;
      out_v_r             <= 1'b0;
    end else if (adv) begin
      st_r    <= st_nxt;
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.event_res       = res_r.event_res;
  assign out_chan.slave_number    = res_r.slave_number;
  assign out_chan.chunk_bytes     = res_r.chunk_bytes;
  assign out_chan.chunk_count     = res_r.chunk_count;
  assign out_chan.dropped_partial = res_r.dropped_partial;
  assign out_chan.job_total       = res_r.job_total;

endmodule
